// ===== hw/rtl/itoa_fmt_pkg.sv =====
// Shared types, constants and character functions of the integer-to-ASCII formatter.
package itoa_fmt_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CharW  = 8;
  localparam int unsigned DigW   = 4;
  localparam int unsigned MaxDig = 16;
  localparam int unsigned CntW   = $clog2(MaxDig + 1);

  localparam logic [CmdW-1:0] CmdSdec = 3'd0;
  localparam logic [CmdW-1:0] CmdUdec = 3'd1;
  localparam logic [CmdW-1:0] CmdHexL = 3'd2;
  localparam logic [CmdW-1:0] CmdHexU = 3'd3;
  localparam logic [CmdW-1:0] CmdPtr  = 3'd4;

  // ceil(2^35 / 10): floor(v * RecipTen / 2^35) == v / 10 for any 32-bit v
  localparam logic [31:0] RecipTen  = 32'hCCCC_CCCD;
  localparam int unsigned RecipShft = 35;

  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharMinus  = 8'h2d;
  localparam logic [CharW-1:0] CharLowX   = 8'h78;
  localparam logic [CharW-1:0] CharLowA   = 8'h61;
  localparam logic [CharW-1:0] CharUpA    = 8'h41;
  localparam logic [CharW-1:0] CharLParen = 8'h28;
  localparam logic [CharW-1:0] CharLowN   = 8'h6e;
  localparam logic [CharW-1:0] CharLowI   = 8'h69;
  localparam logic [CharW-1:0] CharLowL   = 8'h6c;
  localparam logic [CharW-1:0] CharRParen = 8'h29;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDig,
    StPre,
    StDigs,
    StNil
  } state_e;

  function automatic logic [CharW-1:0] digit_char(input logic [DigW-1:0] d,
                                                  input logic upper);
    logic [CharW-1:0] base;
    base = upper ? CharUpA : CharLowA;
    if (d < 4'd10) begin
      digit_char = CharZero + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d - 4'd10};
    end
  endfunction

  function automatic logic [CharW-1:0] nil_char(input logic [2:0] idx);
    unique case (idx)
      3'd0:    nil_char = CharLParen;
      3'd1:    nil_char = CharLowN;
      3'd2:    nil_char = CharLowI;
      3'd3:    nil_char = CharLowL;
      default: nil_char = CharRParen;
    endcase
  endfunction

endpackage

// ===== hw/rtl/itoa_fmt_in_if.sv =====
// Input channel of the formatter: command and value words.
interface itoa_fmt_in_if;
  logic                                valid;
  logic                                ready;
  logic [itoa_fmt_pkg::CmdW-1:0]       command;
  logic [itoa_fmt_pkg::ValueW-1:0]     value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== hw/rtl/itoa_fmt_out_if.sv =====
// Output channel of the formatter: one character word with a last flag.
interface itoa_fmt_out_if;
  logic                              valid;
  logic                              ready;
  logic [itoa_fmt_pkg::CharW-1:0]    ascii_char;
  logic                              last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer-to-ASCII formatter: digit sequencer and character output.
//
//   channel | dir | word
//   in_i    | in  | command[2:0], value[63:0]
//   out_o   | out | ascii_char[7:0], last
//
// Decimal digits come from a shared 32x32 reciprocal multiplier, with a multiply state
// and a digit state per digit; hex digits take one digit state each (up to 16 digits).
// Then one character leaves per cycle unless out_o stalls: at most 18 for a pointer.
// in_i.ready is high only in idle; out_o stalls hold the sequencer in place.
// Reset returns the sequencer to idle; unused commands are dropped with no output.
module integer_to_ascii_formatter (
  input  logic           clk_i,
  input  logic           rst_ni,
  itoa_fmt_in_if.sink    in_i,
  itoa_fmt_out_if.source out_o
);

  itoa_fmt_pkg::state_e state_q, state_d;

  logic [itoa_fmt_pkg::CmdW-1:0]   cmd_q, cmd_d;
  logic                            neg_q, neg_d;
  logic [itoa_fmt_pkg::ValueW-1:0] v_q, v_d;
  logic [63:0]                     prod_q, prod_d;
  logic [itoa_fmt_pkg::ValueW-1:0] dig_q, dig_d;
  logic [itoa_fmt_pkg::CntW-1:0]   n_q, n_d;
  logic [2:0]                      idx_q, idx_d;

  logic                            in_acc;
  logic                            out_acc;
  logic                            is_dec;
  logic                            has_pre;
  logic                            pre_end;
  logic [28:0]                     quot;
  logic [31:0]                     rem;
  logic [itoa_fmt_pkg::DigW-1:0]   digit;
  logic [itoa_fmt_pkg::ValueW-1:0] v_next;
  logic [31:0]                     neg_low;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign is_dec  = (cmd_q == itoa_fmt_pkg::CmdSdec) || (cmd_q == itoa_fmt_pkg::CmdUdec);
  assign has_pre = neg_q || (cmd_q == itoa_fmt_pkg::CmdPtr);
  assign pre_end = (cmd_q == itoa_fmt_pkg::CmdPtr) ? (idx_q == 3'd1) : 1'b1;

  assign quot    = prod_q[63:itoa_fmt_pkg::RecipShft];
  assign rem     = v_q[31:0] - {quot, 3'b000} - {2'b00, quot, 1'b0};
  assign digit   = is_dec ? rem[itoa_fmt_pkg::DigW-1:0] : v_q[itoa_fmt_pkg::DigW-1:0];
  assign v_next  = is_dec ? {35'd0, quot} : (v_q >> itoa_fmt_pkg::DigW);
  assign neg_low = (~in_i.value[31:0]) + 32'd1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itoa_fmt_pkg::StIdle: begin
        if (in_acc) begin
          priority if (in_i.command == itoa_fmt_pkg::CmdSdec ||
                       in_i.command == itoa_fmt_pkg::CmdUdec) begin
            state_d = itoa_fmt_pkg::StMul;
          end else if (in_i.command == itoa_fmt_pkg::CmdHexL ||
                       in_i.command == itoa_fmt_pkg::CmdHexU) begin
            state_d = itoa_fmt_pkg::StDig;
          end else if (in_i.command == itoa_fmt_pkg::CmdPtr) begin
            state_d = (in_i.value == '0) ? itoa_fmt_pkg::StNil : itoa_fmt_pkg::StDig;
          end else begin
            state_d = itoa_fmt_pkg::StIdle;
          end
        end
      end
      itoa_fmt_pkg::StMul: state_d = itoa_fmt_pkg::StDig;
      itoa_fmt_pkg::StDig: begin
        priority if (v_next != '0) begin
          state_d = is_dec ? itoa_fmt_pkg::StMul : itoa_fmt_pkg::StDig;
        end else if (has_pre) begin
          state_d = itoa_fmt_pkg::StPre;
        end else begin
          state_d = itoa_fmt_pkg::StDigs;
        end
      end
      itoa_fmt_pkg::StPre: begin
        if (out_acc && pre_end) state_d = itoa_fmt_pkg::StDigs;
      end
      itoa_fmt_pkg::StDigs: begin
        if (out_acc && n_q == itoa_fmt_pkg::CntW'(1)) state_d = itoa_fmt_pkg::StIdle;
      end
      itoa_fmt_pkg::StNil: begin
        if (out_acc && idx_q == 3'd4) state_d = itoa_fmt_pkg::StIdle;
      end
      default: state_d = itoa_fmt_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready       = 1'b0;
    out_o.valid      = 1'b0;
    out_o.ascii_char = itoa_fmt_pkg::CharZero;
    out_o.last       = 1'b0;
    unique case (state_q)
      itoa_fmt_pkg::StIdle: in_i.ready = 1'b1;
      itoa_fmt_pkg::StPre: begin
        out_o.valid = 1'b1;
        priority if (cmd_q != itoa_fmt_pkg::CmdPtr) begin
          out_o.ascii_char = itoa_fmt_pkg::CharMinus;
        end else if (idx_q == 3'd0) begin
          out_o.ascii_char = itoa_fmt_pkg::CharZero;
        end else begin
          out_o.ascii_char = itoa_fmt_pkg::CharLowX;
        end
      end
      itoa_fmt_pkg::StDigs: begin
        out_o.valid      = 1'b1;
        out_o.ascii_char = itoa_fmt_pkg::digit_char(dig_q[itoa_fmt_pkg::DigW-1:0],
                                                    cmd_q == itoa_fmt_pkg::CmdHexU);
        out_o.last       = (n_q == itoa_fmt_pkg::CntW'(1));
      end
      itoa_fmt_pkg::StNil: begin
        out_o.valid      = 1'b1;
        out_o.ascii_char = itoa_fmt_pkg::nil_char(idx_q);
        out_o.last       = (idx_q == 3'd4);
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    cmd_d  = cmd_q;
    neg_d  = neg_q;
    v_d    = v_q;
    prod_d = prod_q;
    dig_d  = dig_q;
    n_d    = n_q;
    idx_d  = idx_q;
    unique case (state_q)
      itoa_fmt_pkg::StIdle: begin
        if (in_acc) begin
          cmd_d = in_i.command;
          neg_d = (in_i.command == itoa_fmt_pkg::CmdSdec) && in_i.value[31];
          n_d   = '0;
          idx_d = '0;
          priority if (in_i.command == itoa_fmt_pkg::CmdPtr) begin
            v_d = in_i.value;
          end else if (in_i.command == itoa_fmt_pkg::CmdSdec && in_i.value[31]) begin
            v_d = {32'd0, neg_low};
          end else begin
            v_d = {32'd0, in_i.value[31:0]};
          end
        end
      end
      itoa_fmt_pkg::StMul: begin
        prod_d = {32'd0, v_q[31:0]} * {32'd0, itoa_fmt_pkg::RecipTen};
      end
      itoa_fmt_pkg::StDig: begin
        dig_d = {dig_q[itoa_fmt_pkg::ValueW-itoa_fmt_pkg::DigW-1:0], digit};
        n_d   = n_q + itoa_fmt_pkg::CntW'(1);
        v_d   = v_next;
      end
      itoa_fmt_pkg::StPre: begin
        if (out_acc) idx_d = pre_end ? 3'd0 : idx_q + 3'd1;
      end
      itoa_fmt_pkg::StDigs: begin
        if (out_acc) begin
          dig_d = dig_q >> itoa_fmt_pkg::DigW;
          n_d   = n_q - itoa_fmt_pkg::CntW'(1);
        end
      end
      itoa_fmt_pkg::StNil: begin
        if (out_acc) idx_d = idx_q + 3'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_fmt_pkg::StIdle;
      n_q     <= '0;
      idx_q   <= '0;
      cmd_q   <= itoa_fmt_pkg::CmdUdec;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      cmd_q   <= cmd_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    prod_q <= prod_d;
    dig_q  <= dig_d;
  end

endmodule

// ===== tb/sv/itoa_fmt_text_checker.sv =====
// Checker of the integer-to-ASCII formatter: predicts each text from the input words and compares.
module itoa_fmt_text_checker
  import itoa_fmt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  itoa_fmt_in_if  in_mon,
  itoa_fmt_out_if out_mon,
  output int      fail_count_o,
  output int      pending_words_o,
  output int      words_checked_o,
  output int      texts_predicted_o
);

  typedef struct packed {
    logic [CharW-1:0] ascii_char;
    logic             last;
  } text_word_t;

  text_word_t expected_text[$];

  function automatic logic [CharW-1:0] hex_digit(input logic [3:0] d, input bit upper);
    if (d < 4'd10) begin
      return CharZero + CharW'(d);
    end
    return (upper ? CharUpA : CharLowA) + CharW'(d - 4'd10);
  endfunction

  function automatic void format_item(input logic [CmdW-1:0] cmd,
                                      input logic [ValueW-1:0] val);
    logic [CharW-1:0] text[$];
    logic [CharW-1:0] digs[$];
    logic [ValueW-1:0] num;
    logic [31:0] low;
    int radix;
    bit upper;
    text_word_t w;
    low = val[31:0];
    radix = 0;
    upper = 1'b0;
    num = '0;
    case (cmd)
      CmdSdec: begin
        if (low[31]) begin
          text.push_back(CharMinus);
          low = (~low) + 32'd1;
        end
        num = {32'd0, low};
        radix = 10;
      end
      CmdUdec: begin
        num = {32'd0, low};
        radix = 10;
      end
      CmdHexL: begin
        num = {32'd0, low};
        radix = 16;
      end
      CmdHexU: begin
        num = {32'd0, low};
        radix = 16;
        upper = 1'b1;
      end
      CmdPtr: begin
        if (val == '0) begin
          text.push_back(CharLParen);
          text.push_back(CharLowN);
          text.push_back(CharLowI);
          text.push_back(CharLowL);
          text.push_back(CharRParen);
        end else begin
          text.push_back(CharZero);
          text.push_back(CharLowX);
          num = val;
          radix = 16;
        end
      end
      default: begin
      end
    endcase
    if (radix != 0) begin
      do begin
        digs.push_front(hex_digit(4'(num % ValueW'(radix)), upper));
        num = num / ValueW'(radix);
      end while (num != '0);
      foreach (digs[k]) text.push_back(digs[k]);
    end
    foreach (text[k]) begin
      w.ascii_char = text[k];
      w.last = (k == text.size() - 1);
      expected_text.push_back(w);
    end
    if (text.size() != 0) texts_predicted_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_word_t exp_w;
    if (!rst_ni) begin
      expected_text.delete();
      fail_count_o = 0;
      pending_words_o = 0;
      words_checked_o = 0;
      texts_predicted_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        format_item(in_mon.command, in_mon.value);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected word: expected none actual char %h last %b",
                   $time, out_mon.ascii_char, out_mon.last);
          fail_count_o++;
        end else begin
          exp_w = expected_text.pop_front();
          words_checked_o++;
          if (out_mon.ascii_char !== exp_w.ascii_char) begin
            $display("%0t: ascii_char mismatch: expected %h actual %h",
                     $time, exp_w.ascii_char, out_mon.ascii_char);
            fail_count_o++;
          end
          if (out_mon.last !== exp_w.last) begin
            $display("%0t: last mismatch: expected %b actual %b",
                     $time, exp_w.last, out_mon.last);
            fail_count_o++;
          end
        end
      end
      pending_words_o = expected_text.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the formatter testbench: clock, reset, input words, output stalls and verdict.
module testbench;
  import itoa_fmt_pkg::*;

  localparam logic [CmdW-1:0] CmdRsv5 = 3'd5;
  localparam logic [CmdW-1:0] CmdRsv6 = 3'd6;
  localparam logic [CmdW-1:0] CmdRsv7 = 3'd7;
  localparam int RandPerPhase = 26;
  localparam int HoldCycles   = 400;

  logic clk_i;
  logic rst_ni;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int items_sent;
  int fail_count;
  int pending_words;
  int words_checked;
  int texts_predicted;

  itoa_fmt_in_if  in_ch ();
  itoa_fmt_out_if out_ch ();

  integer_to_ascii_formatter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  itoa_fmt_text_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_mon            (in_ch),
    .out_mon           (out_ch),
    .fail_count_o      (fail_count),
    .pending_words_o   (pending_words),
    .words_checked_o   (words_checked),
    .texts_predicted_o (texts_predicted)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #(8 * 400000);
    $display("%0t: timeout", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic push_item(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= val;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = ValueW'($urandom_range(20));
      1: v = v >> $urandom_range(63);
      2: v = {v[63:32], 32'h8000_0000 ^ 32'($urandom_range(3))};
      3: v = {v[63:32], 32'($urandom_range(9)) * 32'd1000000000};
      4: v = ~(v >> $urandom_range(63));
      default: begin
      end
    endcase
    return v;
  endfunction

  task automatic run_directed();
    push_item(CmdSdec, 64'd0);
    push_item(CmdSdec, 64'd1);
    push_item(CmdSdec, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(CmdSdec, 64'h0000_0000_8000_0000);
    push_item(CmdSdec, 64'h1234_5678_7FFF_FFFF);
    push_item(CmdSdec, 64'hFFFF_FFFF_8000_0001);
    push_item(CmdUdec, 64'd0);
    push_item(CmdUdec, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(CmdUdec, 64'hA5A5_A5A5_0000_000A);
    push_item(CmdHexL, 64'd0);
    push_item(CmdHexL, 64'h0000_0000_DEAD_BEEF);
    push_item(CmdHexL, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(CmdHexU, 64'h0000_0000_ABCD_EF01);
    push_item(CmdHexU, 64'hFFFF_FFFF_0000_000F);
    push_item(CmdPtr,  64'd0);
    push_item(CmdPtr,  64'd1);
    push_item(CmdPtr,  64'hFFFF_FFFF_FFFF_FFFF);
    push_item(CmdPtr,  64'h8000_0000_0000_0000);
    push_item(CmdPtr,  64'h0000_0001_0000_0000);
    push_item(CmdRsv5, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(CmdRsv6, 64'd0);
    push_item(CmdRsv7, 64'h0123_4567_89AB_CDEF);
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    logic [CmdW-1:0] cmd;
    int real_items;
    send_idle_pct = 34;
    recv_idle_pct = 67;
    hold_req = 1'b0;
    items_sent = 0;
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CmdSdec;
    in_ch.value   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req = 1'b1;
        end
      endcase
      if (phase == 0) run_directed();
      real_items = 0;
      while (real_items < RandPerPhase) begin
        if ($urandom_range(9) == 0) begin
          cmd = CmdW'($urandom_range(CmdRsv7, CmdRsv5));
        end else begin
          cmd = CmdW'($urandom_range(CmdPtr));
          real_items++;
        end
        push_item(cmd, pick_value());
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d input words over three idle patterns and one long output hold-off;",
             items_sent);
    $display("checked %0d output words from %0d predicted texts.",
             words_checked, texts_predicted);
    if (fail_count == 0 && pending_words == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/itoa_fmt_pkg.sv
hw/rtl/itoa_fmt_in_if.sv
hw/rtl/itoa_fmt_out_if.sv
hw/rtl/integer_to_ascii_formatter.sv
tb/sv/itoa_fmt_text_checker.sv
tb/sv/testbench.sv
